// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the matrix multiply blocks. Each one samples
// on the rising edge of clk. The first is masked while rst is high, the
// second is also checked during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define MMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define MMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/mmt_pkg.sv
// ---------------------------------------------------------------------------
// mmt_pkg
// Types, codes and constants shared by the matrix multiply with transpose
// front end, command queue, compute back end and top level.
// ---------------------------------------------------------------------------
package mmt_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int INDEX_W   = 6;
  localparam int VALUE_IN_W = 16;
  localparam int VALUE_W   = 35;
  localparam int POS_W     = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_WR_LEFT  = 2'd0,
    REQ_WR_RIGHT = 2'd1,
    REQ_RUN      = 2'd2
  } req_code_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_ROWS  = 3'd0,
    REG_LEFT_COLS  = 3'd1,
    REG_RIGHT_ROWS = 3'd2,
    REG_RIGHT_COLS = 3'd3,
    REG_LEFT_T     = 3'd4,
    REG_RIGHT_T    = 3'd5
  } cfg_reg_t;

  // classified commands
  typedef enum logic [1:0] {
    CMD_WR_LEFT  = 2'd0,
    CMD_WR_RIGHT = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_DIMS_ERR = 2'd3
  } cmd_kind_t;

  // input item
  typedef struct packed {
    logic [REQ_W-1:0]             req_type;
    logic [INDEX_W-1:0]           elem_index;
    logic signed [VALUE_IN_W-1:0] elem_value;
  } req_t;

  // result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] product_value;
    logic [POS_W-1:0]          product_row;
    logic [POS_W-1:0]          product_col;
    logic                      last_of_run;
    logic                      dims_error;
  } res_t;

  // queue entry
  typedef struct packed {
    cmd_kind_t              kind;
    logic [INDEX_W-1:0]     index;
    logic [VALUE_IN_W-1:0]  value;
  } cmd_t;

  // operand geometry, clamped counts
  typedef struct packed {
    logic [DIM_W-1:0] res_rows;
    logic [DIM_W-1:0] res_cols;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] left_stride;
    logic [DIM_W-1:0] right_stride;
    logic             left_t;
    logic             right_t;
  } geom_t;

  // tag carried with each multiply-accumulate beat
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_run;
    logic             err;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

  // queue status towards the front
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// File: hdl/mmt_queue.sv
// ---------------------------------------------------------------------------
// mmt_queue
// Short first-in first-out queue of classified commands between the front
// end and the compute back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mmt_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mmt_pkg::cmd_t    head_cmd,
  output mmt_pkg::q_status_t status
);
  import mmt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // pointer step with wrap
  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) res = '0;
    else res = p + 1'b1;
    return res;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[tail] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= step_ptr(tail);
      if (pop) head <= step_ptr(head);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head_cmd     = entries[head];
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.valid = (count != '0);

  `MMT_ASSERT(q_no_pop_empty, pop |-> count != '0, "queue popped while empty")
  `MMT_ASSERT(q_no_push_full, push |-> count != CNT_W'(QUEUE_DEPTH),
              "queue pushed while full")
  `MMT_ASSERT(q_count_up, (push && !pop) |=> count == $past(count) + 1'b1,
              "queue count did not follow a push")

endmodule

// File: hdl/mmt_front.sv
// ---------------------------------------------------------------------------
// mmt_front
// Holds the configuration registers, derives the operand geometry and
// classifies each request beat into a queue command.
// ---------------------------------------------------------------------------
module mmt_front #(
  parameter int MAX_DIM = mmt_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  mmt_pkg::req_t                  req,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmt_pkg::DIM_W-1:0]      cfg_data,
  input  mmt_pkg::q_status_t             q_status,
  output logic                           push,
  output mmt_pkg::cmd_t                  push_cmd,
  output mmt_pkg::geom_t                 geom
);
  import mmt_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int CMP_W   = INDEX_W + 1;

  logic [DIM_W-1:0] left_row_count;
  logic [DIM_W-1:0] left_col_count;
  logic [DIM_W-1:0] right_row_count;
  logic [DIM_W-1:0] right_col_count;
  logic             left_transposed;
  logic             right_transposed;

  logic [DIM_W-1:0] lr, lc, rr, rc;
  logic [DIM_W-1:0] inner_l, inner_r;
  logic             keep;
  cmd_kind_t        kind;

  // zero acts as one, above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    else res = v;
    return res;
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_row_count   <= DIM_W'(1);
      left_col_count   <= DIM_W'(1);
      right_row_count  <= DIM_W'(1);
      right_col_count  <= DIM_W'(1);
      left_transposed  <= 1'b0;
      right_transposed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_ROWS:  left_row_count   <= cfg_data;
        REG_LEFT_COLS:  left_col_count   <= cfg_data;
        REG_RIGHT_ROWS: right_row_count  <= cfg_data;
        REG_RIGHT_COLS: right_col_count  <= cfg_data;
        REG_LEFT_T:     left_transposed  <= cfg_data[0];
        REG_RIGHT_T:    right_transposed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operand geometry
  always_comb begin
    lr = clamp_dim(left_row_count);
    lc = clamp_dim(left_col_count);
    rr = clamp_dim(right_row_count);
    rc = clamp_dim(right_col_count);
    inner_l = left_transposed  ? lr : lc;
    inner_r = right_transposed ? rc : rr;
    geom.res_rows     = left_transposed  ? lc : lr;
    geom.res_cols     = right_transposed ? rr : rc;
    geom.inner        = inner_l;
    geom.left_stride  = lc;
    geom.right_stride = rc;
    geom.left_t       = left_transposed;
    geom.right_t      = right_transposed;
  end

  // classify the request beat
  always_comb begin
    keep = 1'b0;
    kind = CMD_RUN;
    case (req.req_type)
      REQ_WR_LEFT: begin
        kind = CMD_WR_LEFT;
        keep = ({1'b0, req.elem_index} < CMP_W'(DEPTH));
      end
      REQ_WR_RIGHT: begin
        kind = CMD_WR_RIGHT;
        keep = ({1'b0, req.elem_index} < CMP_W'(DEPTH));
      end
      REQ_RUN: begin
        kind = (inner_l != inner_r) ? CMD_DIMS_ERR : CMD_RUN;
        keep = 1'b1;
      end
      default: begin
        kind = CMD_RUN;
        keep = 1'b0;
      end
    endcase
  end

  assign req_stall      = q_status.full;
  assign push           = req_valid && !q_status.full && keep;
  assign push_cmd.kind  = kind;
  assign push_cmd.index = req.elem_index;
  assign push_cmd.value = req.elem_value;

endmodule

// File: hdl/mmt_back.sv
// ---------------------------------------------------------------------------
// mmt_back
// Element stores and the multiply-accumulate walk: address issue, store
// read, multiply, accumulate into the result register. The whole pipe
// holds while a result waits under stall.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmt_back #(
  parameter int MAX_DIM    = mmt_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mmt_pkg::ELEM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mmt_pkg::geom_t     geom,
  input  mmt_pkg::cmd_t      q_cmd,
  input  mmt_pkg::q_status_t q_status,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_stall,
  output mmt_pkg::res_t      res
);
  import mmt_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int ADDR_W  = POS_W + DIM_W + 1;

  logic [ELEM_WIDTH-1:0] left_store  [DEPTH];
  logic [ELEM_WIDTH-1:0] right_store [DEPTH];

  logic                  adv;
  logic                  issue;
  logic                  walking;
  logic [POS_W-1:0]      r, c, k;
  logic                  k_last, c_last, r_last;
  tag_t                  issue_tag;
  logic [ADDR_W-1:0]     la_full, ra_full;
  logic [IDX_W-1:0]      la, ra, wr_idx;
  logic [ELEM_WIDTH-1:0] wr_val;

  logic                  s1_valid;
  tag_t                  s1_tag;
  logic signed [ELEM_WIDTH-1:0] a_q, b_q;

  logic                  s2_valid;
  tag_t                  s2_tag;
  logic signed [PROD_W-1:0] prod;
  logic signed [VALUE_W-1:0] prod_ext;
  logic signed [VALUE_W-1:0] acc;
  logic signed [VALUE_W-1:0] sum;

  // pipe advances unless a result is held
  assign adv   = !(res_valid && res_stall);
  assign q_pop = adv && !walking && q_status.valid;
  assign issue = adv && (walking || (q_status.valid && q_cmd.kind == CMD_DIMS_ERR));

  // walk position
  assign k_last = ({1'b0, k} == geom.inner - 1'b1);
  assign c_last = ({1'b0, c} == geom.res_cols - 1'b1);
  assign r_last = ({1'b0, r} == geom.res_rows - 1'b1);

  always_comb begin
    if (walking) begin
      issue_tag.first    = (k == '0);
      issue_tag.last_k   = k_last;
      issue_tag.last_run = k_last && c_last && r_last;
      issue_tag.err      = 1'b0;
      issue_tag.row      = r;
      issue_tag.col      = c;
    end else begin
      issue_tag.first    = 1'b1;
      issue_tag.last_k   = 1'b1;
      issue_tag.last_run = 1'b1;
      issue_tag.err      = 1'b1;
      issue_tag.row      = '0;
      issue_tag.col      = '0;
    end
  end

  // store addresses of the two operands
  always_comb begin
    if (geom.left_t) la_full = ADDR_W'(k) * ADDR_W'(geom.left_stride) + ADDR_W'(r);
    else la_full = ADDR_W'(r) * ADDR_W'(geom.left_stride) + ADDR_W'(k);
    if (geom.right_t) ra_full = ADDR_W'(c) * ADDR_W'(geom.right_stride) + ADDR_W'(k);
    else ra_full = ADDR_W'(k) * ADDR_W'(geom.right_stride) + ADDR_W'(c);
  end
  assign la     = la_full[IDX_W-1:0];
  assign ra     = ra_full[IDX_W-1:0];
  assign wr_idx = q_cmd.index[IDX_W-1:0];

  // element value as stored: low bits, or the raw beat zero extended
  generate
    if (ELEM_WIDTH <= VALUE_IN_W) begin : g_val_narrow
      assign wr_val = q_cmd.value[ELEM_WIDTH-1:0];
    end else begin : g_val_wide
      assign wr_val = {{(ELEM_WIDTH - VALUE_IN_W){1'b0}}, q_cmd.value};
    end
  endgenerate

  // walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      r <= '0;
      c <= '0;
      k <= '0;
    end else if (adv) begin
      if (walking) begin
        if (k_last) begin
          k <= '0;
          if (c_last) begin
            c <= '0;
            if (r_last) begin
              r <= '0;
              walking <= 1'b0;
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end else begin
          k <= k + 1'b1;
        end
      end else if (q_pop && q_cmd.kind == CMD_RUN) begin
        walking <= 1'b1;
      end
    end
  end

  // element stores, registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == CMD_WR_LEFT) left_store[wr_idx] <= wr_val;
    if (q_pop && q_cmd.kind == CMD_WR_RIGHT) right_store[wr_idx] <= wr_val;
    if (adv) begin
      a_q <= left_store[la];
      b_q <= right_store[ra];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // tags and multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= issue_tag;
      s2_tag <= s1_tag;
      prod   <= a_q * b_q;
    end
  end

  // product brought to result width, modulo 2^35
  generate
    if (PROD_W >= VALUE_W) begin : g_prod_trunc
      assign prod_ext = s2_tag.err ? '0 : prod[VALUE_W-1:0];
    end else begin : g_prod_ext
      assign prod_ext = s2_tag.err ? '0 : {{(VALUE_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  endgenerate

  assign sum = (s2_tag.first ? '0 : acc) + prod_ext;

  // accumulate and result register
  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      acc <= sum;
      if (s2_tag.last_k) begin
        res.product_value <= sum;
        res.product_row   <= s2_tag.row;
        res.product_col   <= s2_tag.col;
        res.last_of_run   <= s2_tag.last_run;
        res.dims_error    <= s2_tag.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (adv) res_valid <= s2_valid && s2_tag.last_k;
  end

  `MMT_ASSERT(b_no_pop_walk, q_pop |-> !walking, "command taken during a walk")
  `MMT_ASSERT(b_err_last,
              (res_valid && res.dims_error) |-> (res.last_of_run && res.product_value == '0),
              "dimension error beat not last or not zero")
  `MMT_ASSERT(b_walk_ends, (adv && walking && issue_tag.last_run) |=> !walking,
              "walk kept running past the final element")

endmodule

// File: hdl/matrix_multiply_transpose_core.sv
// ---------------------------------------------------------------------------
// matrix_multiply_transpose_core
// Matrix multiply with optional transposes over two element stores.
// ---------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req): write-left, write-right
// and run beats. A beat is taken when req_valid is high and req_stall low.
// Writes load one element each, one beat per cycle while the four-entry
// command queue has room; a write to an index past the store is dropped.
// A run holds the back end while it walks op(L)*op(R), one
// multiply-accumulate per cycle while no result is held under stall;
// results follow row-major on the result channel (res_valid /
// res_stall / res), the final one marked last_of_run. From an idle block
// and with no stall, the first result passes walk issue, the registered
// store read, the multiply register and the result register before
// res_valid rises. Mismatched inner dimensions give one dims_error beat.
// The multiply-accumulate walk is the rate limit: one store read pair per
// cycle on each store's single read port while the pipe is not held.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready and must be written while no work is in flight.
// While res_stall holds a result, the whole compute pipe freezes and the
// queue fills, after which req_stall rises. Synchronous reset empties the
// queue and pipe and sets counts to one and transposes off; store contents
// are undefined until written.
// ---------------------------------------------------------------------------
module matrix_multiply_transpose_core #(
  parameter int MAX_DIM    = mmt_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mmt_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  mmt_pkg::req_t                  req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output mmt_pkg::res_t                  res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmt_pkg::DIM_W-1:0]      cfg_data
);
  import mmt_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;
  geom_t     geom;

  // front: configuration and classification
  mmt_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd),
    .geom      (geom)
  );

  // command queue
  mmt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // back: stores and multiply-accumulate walk
  mmt_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_cmd     (head_cmd),
    .q_status  (q_status),
    .q_pop     (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
